>>> rtl/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared types and constants for the robot target search sequencer.
// ----------------------------------------------------------------------------
package rtss_pkg;

   // request op codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   // event kinds
   localparam logic [2:0] EV_TARGET      = 3'd0;
   localparam logic [2:0] EV_FRONT_LEFT  = 3'd1;
   localparam logic [2:0] EV_FRONT_RIGHT = 3'd2;
   localparam logic [2:0] EV_BOOM_FRONT  = 3'd3;
   localparam logic [2:0] EV_BOOM_BACK   = 3'd4;
   localparam logic [2:0] EV_BACK_LEFT   = 3'd5;
   localparam logic [2:0] EV_BACK_RIGHT  = 3'd6;

   // search modes (data values carried on mode_now)
   localparam logic [3:0] MODE_INIT        = 4'd0;
   localparam logic [3:0] MODE_SEARCH_WALL = 4'd1;
   localparam logic [3:0] MODE_DRIFT_OFF   = 4'd2;
   localparam logic [3:0] MODE_DRIFT_CTR   = 4'd3;
   localparam logic [3:0] MODE_SPIN_OFF    = 4'd4;
   localparam logic [3:0] MODE_DRIFT_ON    = 4'd5;
   localparam logic [3:0] MODE_DRIFT_HARD  = 4'd6;
   localparam logic [3:0] MODE_SUPER_SPIN  = 4'd7;
   localparam logic [3:0] MODE_PUSH        = 4'd8;
   localparam logic [3:0] MODE_PUSH_LEFT   = 4'd9;
   localparam logic [3:0] MODE_PUSH_RIGHT  = 4'd10;
   localparam logic [3:0] MODE_REVERSE     = 4'd11;
   localparam logic [3:0] MODE_SCRAMBLE    = 4'd12;

   // timer indexes, in tick service order
   localparam int unsigned NUM_TIMERS = 7;
   localparam logic [2:0] TMR_REVERSE    = 3'd0;
   localparam logic [2:0] TMR_SEARCH     = 3'd1;
   localparam logic [2:0] TMR_SCRAMBLE   = 3'd2;
   localparam logic [2:0] TMR_DRIFT_ON   = 3'd3;
   localparam logic [2:0] TMR_DRIFT_HARD = 3'd4;
   localparam logic [2:0] TMR_DRIFT_CTR  = 3'd5;
   localparam logic [2:0] TMR_SUPER_SPIN = 3'd6;

   // register indexes
   localparam logic [2:0] REG_SEARCH_MODE = 3'd0;

   localparam int unsigned LIMIT_BITS = 12;

   // motor directions
   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   // duty values
   localparam logic [7:0] DUTY_BASE      = 8'd200;
   localparam logic [7:0] DUTY_HALF      = 8'd100;
   localparam logic [7:0] DUTY_SPIN      = 8'd60;
   localparam logic [7:0] DUTY_SUPER     = 8'd250;
   localparam logic [7:0] DUTY_REV_B     = 8'd120;  // base - 80
   localparam logic [7:0] DUTY_FIVE_SEV  = 8'd142;  // base * 5 / 7
   localparam logic [7:0] DUTY_FIVE_NINE = 8'd111;  // base * 5 / 9
   localparam logic [7:0] DUTY_FOUR_FIVE = 8'd160;  // base * 4 / 5
   localparam logic [7:0] DUTY_TWO_THRD  = 8'd133;  // base * 2 / 3

   // centered target window, Q.8
   localparam logic [8:0] CTR_X_LO = 9'd90;
   localparam logic [8:0] CTR_X_HI = 9'd166;
   localparam logic [8:0] CTR_Y_LO = 9'd193;
   localparam logic [8:0] X_MID    = 9'd128;
   localparam logic [8:0] X_FULL   = 9'd256;

   typedef struct packed {
      logic [1:0] a_dir;
      logic [7:0] a_duty;
      logic [1:0] b_dir;
      logic [7:0] b_duty;
   } motor_cmd_type;

   // controller to datapath
   typedef struct packed {
      logic       load;    // capture request payload
      logic       start;
      logic       event_step;
      logic       timer_step;
      logic [2:0] timer_idx;
      logic       flush;   // release the held result as the final one
   } step_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_ok;
   } step_status_type;

endpackage

>>> rtl/rtss_req_if.sv
// ----------------------------------------------------------------------------
// rtss_req_if
// Request channel: start, tick and sensor events.
// ----------------------------------------------------------------------------
interface rtss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [2:0] event_kind;
   logic [8:0] param_a;
   logic [8:0] param_b;

   modport source (output valid, op, event_kind, param_a, param_b, input ready);
   modport sink   (input valid, op, event_kind, param_a, param_b, output ready);
endinterface

>>> rtl/rtss_rsp_if.sv
// ----------------------------------------------------------------------------
// rtss_rsp_if
// Result channel: one motor command per transfer.
// ----------------------------------------------------------------------------
interface rtss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] motor_a_dir;
   logic [7:0] motor_a_duty;
   logic [1:0] motor_b_dir;
   logic [7:0] motor_b_duty;
   logic [3:0] mode_now;
   logic       last;

   modport source (output valid, motor_a_dir, motor_a_duty, motor_b_dir, motor_b_duty,
                   mode_now, last, input ready);
   modport sink   (input valid, motor_a_dir, motor_a_duty, motor_b_dir, motor_b_duty,
                   mode_now, last, output ready);
endinterface

>>> rtl/rtss_ctrl.sv
// ----------------------------------------------------------------------------
// rtss_ctrl
// Sequencer: accepts a request and walks its steps through the datapath.
// ----------------------------------------------------------------------------
module rtss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_op,
   output logic                     req_ready,
   input  rtss_pkg::step_status_type status,
   output rtss_pkg::step_cmd_type   cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_EVENT = 5'b00100,
      ST_TICK  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] tidx_ff, tidx_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and step commands
   always_comb begin
      state_in = state_ff;
      tidx_in  = tidx_ff;
      cmd      = '0;
      cmd.timer_idx = tidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               tidx_in  = rtss_pkg::TMR_REVERSE;
               unique case (req_op)
                  rtss_pkg::OP_START: state_in = ST_START;
                  rtss_pkg::OP_TICK:  state_in = ST_TICK;
                  rtss_pkg::OP_EVENT: state_in = ST_EVENT;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_START: begin
            if (status.step_ok) begin
               cmd.start = 1'b1;
               state_in  = ST_FLUSH;
            end
         end
         ST_EVENT: begin
            if (status.step_ok) begin
               cmd.event_step = 1'b1;
               state_in       = ST_FLUSH;
            end
         end
         ST_TICK: begin
            if (status.step_ok) begin
               cmd.timer_step = 1'b1;
               if (tidx_ff == rtss_pkg::TMR_SUPER_SPIN) begin
                  state_in = ST_FLUSH;
               end else begin
                  tidx_in = tidx_ff + 3'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (status.step_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tidx_ff  <= tidx_in;
      end
   end

endmodule

>>> rtl/rtss_datapath.sv
// ----------------------------------------------------------------------------
// rtss_datapath
// Mode state, timers, boom flag, steering and the result registers.
// ----------------------------------------------------------------------------
module rtss_datapath #(
   parameter int unsigned TIMER_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rtss_pkg::step_cmd_type    cmd,
   output rtss_pkg::step_status_type status,
   input  logic [2:0]                req_event_kind,
   input  logic [8:0]                req_param_a,
   input  logic [8:0]                req_param_b,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_index,
   input  logic [11:0]               csr_write_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_motor_a_dir,
   output logic [7:0]                rsp_motor_a_duty,
   output logic [1:0]                rsp_motor_b_dir,
   output logic [7:0]                rsp_motor_b_duty,
   output logic [3:0]                rsp_mode_now,
   output logic                      rsp_last
);

   localparam int unsigned NT = rtss_pkg::NUM_TIMERS;
   localparam int unsigned LB = rtss_pkg::LIMIT_BITS;
   localparam int unsigned LW = (TIMER_BITS > LB) ? TIMER_BITS : LB;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   // configuration
   logic                 smode_ff;
   logic [LB-1:0]        limit_ff [NT];

   // block state
   logic [3:0]            mode_ff, mode_in;
   logic                  boom_ff, boom_in;
   logic [TIMER_BITS-1:0] cnt_ff [NT];
   logic [TIMER_BITS-1:0] cnt_in [NT];
   logic [NT-1:0]         armed_ff, armed_in;

   // captured request
   logic [2:0] kind_ff;
   logic [8:0] a_ff, b_ff;

   // held result and output register
   rtss_pkg::motor_cmd_type pend_cmd_ff, out_cmd_ff;
   logic [3:0]              pend_mode_ff, out_mode_ff;
   logic                    pend_valid_ff, out_valid_ff, out_last_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smode_ff    <= 1'b0;
         limit_ff[0] <= 12'd600;
         limit_ff[1] <= 12'd3000;
         limit_ff[2] <= 12'd500;
         limit_ff[3] <= 12'd500;
         limit_ff[4] <= 12'd1500;
         limit_ff[5] <= 12'd100;
         limit_ff[6] <= 12'd120;
      end else if (csr_write_enable) begin
         if (csr_index == rtss_pkg::REG_SEARCH_MODE) begin
            smode_ff <= csr_write_data[0];
         end else begin
            limit_ff[csr_index - 3'd1] <= csr_write_data;
         end
      end
   end

   // capture payload on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_event_kind;
         a_ff    <= req_param_a;
         b_ff    <= req_param_b;
      end
   end

   // current timer: saturating increment and expiry check
   logic [TIMER_BITS-1:0] tcnt, tcnt_inc;
   logic [LW-1:0]         lim_ext, lim_eff;
   logic                  t_armed, t_fire;

   always_comb begin
      tcnt     = cnt_ff[cmd.timer_idx];
      t_armed  = armed_ff[cmd.timer_idx];
      tcnt_inc = (tcnt == TMAX) ? tcnt : tcnt + 1'b1;
      lim_ext  = LW'(limit_ff[cmd.timer_idx]);
      lim_eff  = (lim_ext > LW'(TMAX)) ? LW'(TMAX) : lim_ext;
      t_fire   = cmd.timer_step && t_armed && (LW'(tcnt) >= lim_eff);
   end

   // signal seen by the mode machine this step
   logic       sv, is_to, act, front;
   logic [2:0] sidx;
   logic [8:0] sa, sb;

   always_comb begin
      sv    = (cmd.event_step && (kind_ff <= rtss_pkg::EV_BACK_RIGHT)) || t_fire;
      is_to = cmd.timer_step;
      sidx  = cmd.timer_step ? cmd.timer_idx : kind_ff;
      sa    = cmd.timer_step ? 9'd0 : a_ff;
      sb    = cmd.timer_step ? 9'd0 : b_ff;
      act   = (sa != 9'd0);
      front = sv && !is_to && act &&
              ((sidx == rtss_pkg::EV_FRONT_LEFT) || (sidx == rtss_pkg::EV_FRONT_RIGHT));
   end

   // proportional steering with damping
   logic [8:0]  x_clip, x_off;
   logic [7:0]  base_duty, v_raw, v_damp;
   logic [16:0] prod;
   logic [9:0]  rest3;
   rtss_pkg::motor_cmd_type steer_cmd;

   always_comb begin
      x_clip    = (sa > rtss_pkg::X_FULL) ? rtss_pkg::X_FULL : sa;
      base_duty = boom_ff ? rtss_pkg::DUTY_HALF : rtss_pkg::DUTY_BASE;
      x_off     = (x_clip < rtss_pkg::X_MID) ? x_clip : x_clip - rtss_pkg::X_MID;
      prod      = 17'(x_off) * 17'(base_duty);
      v_raw     = prod[14:7];
      rest3     = 10'(base_duty - v_raw) * 10'd3;
      v_damp    = v_raw + rest3[9:2];
      steer_cmd = '{rtss_pkg::DIR_FWD, base_duty, rtss_pkg::DIR_FWD, base_duty};
      if (x_clip < rtss_pkg::X_MID) begin
         steer_cmd.b_duty = v_damp;
      end else if (x_clip > rtss_pkg::X_MID) begin
         steer_cmd.a_duty = v_damp;
      end
   end

   function automatic logic ev(input logic v, input logic t, input logic [2:0] i,
                               input logic [2:0] k);
      return v && !t && (i == k);
   endfunction

   function automatic logic tm(input logic v, input logic t, input logic [2:0] i,
                               input logic [2:0] k);
      return v && t && (i == k);
   endfunction

   // react to the signal in the current mode
   logic                    move, here_emit, here_arm;
   logic [3:0]              ns;
   rtss_pkg::motor_cmd_type here_cmd;
   logic                    centered;

   always_comb begin
      move      = 1'b0;
      ns        = mode_ff;
      here_emit = 1'b0;
      here_arm  = 1'b0;
      here_cmd  = steer_cmd;
      centered  = (sa >= rtss_pkg::CTR_X_LO) && (sa <= rtss_pkg::CTR_X_HI) &&
                  (sb >= rtss_pkg::CTR_Y_LO);
      unique case (mode_ff)
         rtss_pkg::MODE_SEARCH_WALL: begin
            if (ev(sv, is_to, sidx, rtss_pkg::EV_TARGET)) begin
               if (centered) begin
                  move = 1'b1;
                  ns   = smode_ff ? rtss_pkg::MODE_SUPER_SPIN : rtss_pkg::MODE_PUSH;
               end else begin
                  here_emit = 1'b1;
                  here_arm  = 1'b1;
               end
            end else if (front) begin
               move = 1'b1; ns = rtss_pkg::MODE_REVERSE;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_FRONT) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_DRIFT_OFF;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_BACK) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_SPIN_OFF;
            end else if (tm(sv, is_to, sidx, rtss_pkg::TMR_SEARCH)) begin
               move = 1'b1; ns = rtss_pkg::MODE_SCRAMBLE;
            end
         end
         rtss_pkg::MODE_DRIFT_OFF, rtss_pkg::MODE_DRIFT_CTR,
         rtss_pkg::MODE_DRIFT_ON, rtss_pkg::MODE_DRIFT_HARD: begin
            if (ev(sv, is_to, sidx, rtss_pkg::EV_TARGET)) begin
               move = 1'b1; ns = rtss_pkg::MODE_SEARCH_WALL;
            end else if (front) begin
               move = 1'b1; ns = rtss_pkg::MODE_REVERSE;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_FRONT)) begin
               if (mode_ff == rtss_pkg::MODE_DRIFT_OFF) begin
                  if (!act) begin
                     move = 1'b1; ns = rtss_pkg::MODE_DRIFT_CTR;
                  end
               end else if (act) begin
                  move = 1'b1; ns = rtss_pkg::MODE_DRIFT_OFF;
               end
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_BACK) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_SPIN_OFF;
            end else if (mode_ff == rtss_pkg::MODE_DRIFT_CTR &&
                         tm(sv, is_to, sidx, rtss_pkg::TMR_DRIFT_CTR)) begin
               move = 1'b1; ns = rtss_pkg::MODE_DRIFT_ON;
            end else if (mode_ff == rtss_pkg::MODE_DRIFT_ON &&
                         tm(sv, is_to, sidx, rtss_pkg::TMR_DRIFT_ON)) begin
               move = 1'b1; ns = rtss_pkg::MODE_DRIFT_HARD;
            end else if (mode_ff == rtss_pkg::MODE_DRIFT_HARD &&
                         tm(sv, is_to, sidx, rtss_pkg::TMR_DRIFT_HARD)) begin
               move = 1'b1; ns = rtss_pkg::MODE_SEARCH_WALL;
            end
         end
         rtss_pkg::MODE_SPIN_OFF: begin
            if (front) begin
               move = 1'b1; ns = rtss_pkg::MODE_REVERSE;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_FRONT) && !act) begin
               move = 1'b1; ns = rtss_pkg::MODE_DRIFT_CTR;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_BACK) && !act) begin
               here_emit = 1'b1;
               here_cmd  = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_FOUR_FIVE,
                             rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE};
            end
         end
         rtss_pkg::MODE_SUPER_SPIN: begin
            if (tm(sv, is_to, sidx, rtss_pkg::TMR_SUPER_SPIN)) begin
               move = 1'b1; ns = rtss_pkg::MODE_SEARCH_WALL;
            end
         end
         rtss_pkg::MODE_PUSH: begin
            if ((ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_FRONT) ||
                 ev(sv, is_to, sidx, rtss_pkg::EV_BOOM_BACK)) && act) begin
               here_emit = 1'b1;
               here_cmd  = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_TWO_THRD,
                             rtss_pkg::DIR_FWD, rtss_pkg::DUTY_TWO_THRD};
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_LEFT) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_PUSH_RIGHT;
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_RIGHT) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_PUSH_LEFT;
            end
         end
         rtss_pkg::MODE_PUSH_LEFT: begin
            if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_RIGHT)) begin
               here_emit = 1'b1;
               here_cmd  = act ? '{rtss_pkg::DIR_REV, rtss_pkg::DUTY_SPIN,
                                   rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SPIN}
                               : '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE,
                                   rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE};
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_LEFT) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_REVERSE;
            end
         end
         rtss_pkg::MODE_PUSH_RIGHT: begin
            if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_LEFT)) begin
               here_emit = 1'b1;
               here_cmd  = act ? '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SPIN,
                                   rtss_pkg::DIR_REV, rtss_pkg::DUTY_SPIN}
                               : '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE,
                                   rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE};
            end else if (ev(sv, is_to, sidx, rtss_pkg::EV_FRONT_RIGHT) && act) begin
               move = 1'b1; ns = rtss_pkg::MODE_REVERSE;
            end
         end
         rtss_pkg::MODE_REVERSE: begin
            if (tm(sv, is_to, sidx, rtss_pkg::TMR_REVERSE) ||
                ((ev(sv, is_to, sidx, rtss_pkg::EV_BACK_LEFT) ||
                  ev(sv, is_to, sidx, rtss_pkg::EV_BACK_RIGHT)) && act)) begin
               move = 1'b1; ns = rtss_pkg::MODE_DRIFT_ON;
            end
         end
         rtss_pkg::MODE_SCRAMBLE: begin
            if (tm(sv, is_to, sidx, rtss_pkg::TMR_SCRAMBLE) ||
                ev(sv, is_to, sidx, rtss_pkg::EV_TARGET)) begin
               move = 1'b1; ns = rtss_pkg::MODE_SEARCH_WALL;
            end
         end
         default: begin
         end
      endcase
      // start enters the first mode straight from whatever mode is current
      if (cmd.start) begin
         move      = 1'b1;
         here_emit = 1'b0;
         here_arm  = 1'b0;
         ns        = smode_ff ? rtss_pkg::MODE_SEARCH_WALL : rtss_pkg::MODE_PUSH;
      end
   end

   // entry action of the new mode
   rtss_pkg::motor_cmd_type entry_cmd;
   logic                    entry_arm;
   logic [2:0]              entry_idx;

   always_comb begin
      entry_arm = 1'b0;
      entry_idx = rtss_pkg::TMR_REVERSE;
      entry_cmd = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_FOUR_FIVE,
                    rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE};
      unique case (ns)
         rtss_pkg::MODE_SEARCH_WALL: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_SEARCH;
         end
         rtss_pkg::MODE_DRIFT_CTR: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_DRIFT_CTR;
         end
         rtss_pkg::MODE_DRIFT_ON: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_DRIFT_ON;
            entry_cmd = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_FIVE_SEV};
         end
         rtss_pkg::MODE_DRIFT_HARD: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_DRIFT_HARD;
            entry_cmd = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_FIVE_NINE};
         end
         rtss_pkg::MODE_SPIN_OFF, rtss_pkg::MODE_PUSH_LEFT: begin
            entry_cmd = '{rtss_pkg::DIR_REV, rtss_pkg::DUTY_SPIN,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SPIN};
         end
         rtss_pkg::MODE_SCRAMBLE: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_SCRAMBLE;
            entry_cmd = '{rtss_pkg::DIR_REV, rtss_pkg::DUTY_SPIN,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SPIN};
         end
         rtss_pkg::MODE_SUPER_SPIN: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_SUPER_SPIN;
            entry_cmd = '{rtss_pkg::DIR_REV, rtss_pkg::DUTY_SUPER,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SUPER};
         end
         rtss_pkg::MODE_PUSH: begin
            entry_cmd = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE,
                          rtss_pkg::DIR_FWD, rtss_pkg::DUTY_BASE};
         end
         rtss_pkg::MODE_PUSH_RIGHT: begin
            entry_cmd = '{rtss_pkg::DIR_FWD, rtss_pkg::DUTY_SPIN,
                          rtss_pkg::DIR_REV, rtss_pkg::DUTY_SPIN};
         end
         rtss_pkg::MODE_REVERSE: begin
            entry_arm = 1'b1; entry_idx = rtss_pkg::TMR_REVERSE;
            entry_cmd = '{rtss_pkg::DIR_REV, rtss_pkg::DUTY_BASE,
                          rtss_pkg::DIR_REV, rtss_pkg::DUTY_REV_B};
         end
         default: begin
         end
      endcase
   end

   // one result per step at most
   logic                    step, gen, exit_search;
   rtss_pkg::motor_cmd_type res_cmd;
   logic [3:0]              res_mode;

   always_comb begin
      step        = cmd.start || cmd.event_step || cmd.timer_step;
      gen         = step && (here_emit || move);
      res_cmd     = move ? entry_cmd : here_cmd;
      res_mode    = move ? ns : mode_ff;
      exit_search = step && move && !cmd.start && (mode_ff == rtss_pkg::MODE_SEARCH_WALL);
      mode_in     = (step && move) ? ns : mode_ff;
      boom_in     = boom_ff;
      if (cmd.event_step && kind_ff == rtss_pkg::EV_BOOM_BACK) begin
         boom_in = (a_ff != 9'd0);
      end
   end

   // timer updates: arm clears the count, expiry and leaving search disarm
   always_comb begin
      for (int k = 0; k < NT; k++) begin
         cnt_in[k]   = cnt_ff[k];
         armed_in[k] = armed_ff[k];
         if (cmd.timer_step && t_armed && cmd.timer_idx == 3'(k)) begin
            cnt_in[k] = tcnt_inc;
            if (t_fire) begin
               armed_in[k] = 1'b0;
            end
         end
         if (exit_search && 3'(k) == rtss_pkg::TMR_SEARCH) begin
            armed_in[k] = 1'b0;
         end
         if ((step && here_arm && 3'(k) == rtss_pkg::TMR_SEARCH) ||
             (step && move && entry_arm && entry_idx == 3'(k))) begin
            cnt_in[k]   = '0;
            armed_in[k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rtss_pkg::MODE_INIT;
         boom_ff  <= 1'b0;
         armed_ff <= '0;
         for (int k = 0; k < NT; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         mode_ff  <= mode_in;
         boom_ff  <= boom_in;
         armed_ff <= armed_in;
         for (int k = 0; k < NT; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // hold the newest result until the next one shows whether it is final
   logic out_free, load_out;

   assign out_free       = !out_valid_ff || rsp_ready;
   assign status.step_ok = !pend_valid_ff || out_free;
   assign load_out       = pend_valid_ff && (gen || cmd.flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (gen) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         pend_cmd_ff  <= res_cmd;
         pend_mode_ff <= res_mode;
      end
      if (load_out) begin
         out_cmd_ff  <= pend_cmd_ff;
         out_mode_ff <= pend_mode_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_motor_a_dir  = out_cmd_ff.a_dir;
   assign rsp_motor_a_duty = out_cmd_ff.a_duty;
   assign rsp_motor_b_dir  = out_cmd_ff.b_dir;
   assign rsp_motor_b_duty = out_cmd_ff.b_duty;
   assign rsp_mode_now     = out_mode_ff;
   assign rsp_last         = out_last_ff;

endmodule

>>> rtl/robot_target_search_sequencer.sv
// ----------------------------------------------------------------------------
// robot_target_search_sequencer
// Two-motor search and push sequencer with seven timeout counters.
// ----------------------------------------------------------------------------
// One request is taken at a time. A start or an event passes from its transfer
// to the earliest next transfer through capture, one mode step and release of
// the final result; a tick services the seven timers between capture and
// release, one per cycle when no step waits, in fixed order through the shared
// mode logic. An unknown op is dropped. Every step waits while a held command
// cannot move into an output register that is still full, so a slow result
// sink stalls the sequencer. A tick yields up to seven commands, a start exactly
// one, an event at most one; the final command of a request carries last.
module robot_target_search_sequencer #(
   parameter int unsigned TIMER_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   rtss_req_if.sink    req_chan,
   rtss_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   rtss_pkg::step_cmd_type    cmd;
   rtss_pkg::step_status_type status;

   rtss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rtss_datapath #(.TIMER_BITS(TIMER_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_event_kind   (req_chan.event_kind),
      .req_param_a      (req_chan.param_a),
      .req_param_b      (req_chan.param_b),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_motor_a_dir  (rsp_chan.motor_a_dir),
      .rsp_motor_a_duty (rsp_chan.motor_a_duty),
      .rsp_motor_b_dir  (rsp_chan.motor_b_dir),
      .rsp_motor_b_duty (rsp_chan.motor_b_duty),
      .rsp_mode_now     (rsp_chan.mode_now),
      .rsp_last         (rsp_chan.last)
   );

endmodule

>>> rtl/rtss_checker.sv
// ----------------------------------------------------------------------------
// rtss_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rtss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_motor_a_dir,
   input logic [1:0] rsp_motor_b_dir,
   input logic [3:0] rsp_mode_now,
   input logic       rsp_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_now) && $stable(rsp_last))
      else $error("stalled result changed");

   // drop results during reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // report only real modes
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_now <= 4'd12 && rsp_mode_now != 4'd0)
      else $error("result reports init or unknown mode");

   // drive real directions, never off
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor_a_dir == 2'd1 || rsp_motor_a_dir == 2'd2) &&
                    (rsp_motor_b_dir == 2'd1 || rsp_motor_b_dir == 2'd2))
      else $error("bad motor direction");

endmodule

bind robot_target_search_sequencer rtss_checker u_rtss_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_motor_a_dir (rsp_chan.motor_a_dir),
   .rsp_motor_b_dir (rsp_chan.motor_b_dir),
   .rsp_mode_now    (rsp_chan.mode_now),
   .rsp_last        (rsp_chan.last)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the robot target search sequencer. Requests are
// driven from a queue with random gaps, results are drained with random and
// long stalls, and every motor command is checked against a mode machine
// kept inside the bench, across several register settings.
// ----------------------------------------------------------------------------
module testbench;
   import rtss_pkg::*;

   localparam int SIG_TIMEOUT = 10;
   localparam int SIG_ENTER   = 20;
   localparam int SIG_LEAVE   = 21;
   localparam int NO_MOVE     = -1;
   localparam int TIMER_MAX   = 4095;

   typedef struct {
      logic [1:0] op;
      logic [2:0] kind;
      logic [8:0] pa;
      logic [8:0] pb;
   } req_item_type;

   typedef struct {
      logic [1:0] a_dir;
      logic [7:0] a_duty;
      logic [1:0] b_dir;
      logic [7:0] b_duty;
      logic [3:0] mode;
      logic       last;
   } motor_cmd_exp_type;

   logic clock = 0;
   logic reset = 1;
   logic        csr_write_enable = 0;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_write_data = '0;

   rtss_req_if req_if();
   rtss_rsp_if rsp_if();

   robot_target_search_sequencer dut (
      .clock(clock), .reset(reset),
      .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   req_item_type      pending_q[$];
   motor_cmd_exp_type cmd_exp_q[$];
   int mismatch_count = 0;
   int tx_idle_pct = 6;
   int rx_idle_pct = 74;
   int hold_left = 0;

   // shadow of the sequencer
   bit          mode_sel;
   int unsigned tmr_limit[NUM_TIMERS];
   int unsigned tmr_count[NUM_TIMERS];
   bit          tmr_armed[NUM_TIMERS];
   int          cur_mode;
   bit          boom_back;

   initial begin
      req_if.valid = 0;
      req_if.op = OP_START;
      req_if.event_kind = EV_TARGET;
      req_if.param_a = '0;
      req_if.param_b = '0;
      rsp_if.ready = 0;
      mode_sel = 0;
      tmr_limit = '{600, 3000, 500, 500, 1500, 100, 120};
      tmr_count = '{default: 0};
      tmr_armed = '{default: 0};
      cur_mode = MODE_INIT;
      boom_back = 0;
   end

   initial forever #2 clock = ~clock;

   function automatic void push_cmd(int ad, int aduty, int bd, int bduty);
      motor_cmd_exp_type c;
      c.a_dir = 2'(ad); c.a_duty = 8'(aduty); c.b_dir = 2'(bd); c.b_duty = 8'(bduty);
      c.mode = 4'(cur_mode); c.last = 0;
      cmd_exp_q.push_back(c);
   endfunction

   function automatic void arm_timer(int t);
      tmr_count[t] = 0;
      tmr_armed[t] = 1;
   endfunction

   function automatic void steer_to(int x, int base);
      int v1;
      int v2;
      v1 = base; v2 = base;
      if (x > 256) x = 256;
      if (x < 128) begin
         v2 = x * base / 128;
         v2 += (base - v2) * 3 / 4;
      end
      if (x > 128) begin
         v1 = (x - 128) * base / 128;
         v1 += (base - v1) * 3 / 4;
      end
      push_cmd(DIR_FWD, v1, DIR_FWD, v2);
   endfunction

   // apply one signal to the current mode, return the mode to enter
   function automatic int mode_react(int sig, int a, int b);
      bit act;
      bit front;
      act = a != 0;
      front = (sig == EV_FRONT_LEFT || sig == EV_FRONT_RIGHT) && act;
      case (cur_mode)
         MODE_SEARCH_WALL: begin
            if (sig == SIG_ENTER) begin
               push_cmd(DIR_FWD, DUTY_FOUR_FIVE, DIR_FWD, DUTY_BASE);
               arm_timer(TMR_SEARCH);
            end else if (sig == SIG_LEAVE) tmr_armed[TMR_SEARCH] = 0;
            else if (sig == EV_TARGET) begin
               if (a >= CTR_X_LO && a <= CTR_X_HI && b >= CTR_Y_LO)
                  return mode_sel ? MODE_SUPER_SPIN : MODE_PUSH;
               steer_to(a, boom_back ? DUTY_HALF : DUTY_BASE);
               arm_timer(TMR_SEARCH);
            end
            else if (front) return MODE_REVERSE;
            else if (sig == EV_BOOM_FRONT && act) return MODE_DRIFT_OFF;
            else if (sig == EV_BOOM_BACK && act) return MODE_SPIN_OFF;
            else if (sig == SIG_TIMEOUT + TMR_SEARCH) return MODE_SCRAMBLE;
         end
         MODE_DRIFT_OFF, MODE_DRIFT_CTR, MODE_DRIFT_ON, MODE_DRIFT_HARD: begin
            if (sig == SIG_ENTER) begin
               if (cur_mode == MODE_DRIFT_OFF)
                  push_cmd(DIR_FWD, DUTY_FOUR_FIVE, DIR_FWD, DUTY_BASE);
               else if (cur_mode == MODE_DRIFT_CTR) begin
                  arm_timer(TMR_DRIFT_CTR);
                  push_cmd(DIR_FWD, DUTY_FOUR_FIVE, DIR_FWD, DUTY_BASE);
               end else if (cur_mode == MODE_DRIFT_ON) begin
                  arm_timer(TMR_DRIFT_ON);
                  push_cmd(DIR_FWD, DUTY_BASE, DIR_FWD, DUTY_FIVE_SEV);
               end else begin
                  arm_timer(TMR_DRIFT_HARD);
                  push_cmd(DIR_FWD, DUTY_BASE, DIR_FWD, DUTY_FIVE_NINE);
               end
            end
            else if (sig == EV_TARGET) return MODE_SEARCH_WALL;
            else if (front) return MODE_REVERSE;
            else if (sig == EV_BOOM_FRONT) begin
               if (cur_mode == MODE_DRIFT_OFF) begin
                  if (!act) return MODE_DRIFT_CTR;
               end else if (act) return MODE_DRIFT_OFF;
            end
            else if (sig == EV_BOOM_BACK && act) return MODE_SPIN_OFF;
            else if (cur_mode == MODE_DRIFT_CTR && sig == SIG_TIMEOUT + TMR_DRIFT_CTR)
               return MODE_DRIFT_ON;
            else if (cur_mode == MODE_DRIFT_ON && sig == SIG_TIMEOUT + TMR_DRIFT_ON)
               return MODE_DRIFT_HARD;
            else if (cur_mode == MODE_DRIFT_HARD && sig == SIG_TIMEOUT + TMR_DRIFT_HARD)
               return MODE_SEARCH_WALL;
         end
         MODE_SPIN_OFF: begin
            if (sig == SIG_ENTER) push_cmd(DIR_REV, DUTY_SPIN, DIR_FWD, DUTY_SPIN);
            else if (front) return MODE_REVERSE;
            else if (sig == EV_BOOM_FRONT && !act) return MODE_DRIFT_CTR;
            else if (sig == EV_BOOM_BACK && !act)
               push_cmd(DIR_FWD, DUTY_FOUR_FIVE, DIR_FWD, DUTY_BASE);
         end
         MODE_SUPER_SPIN: begin
            if (sig == SIG_ENTER) begin
               push_cmd(DIR_REV, DUTY_SUPER, DIR_FWD, DUTY_SUPER);
               arm_timer(TMR_SUPER_SPIN);
            end else if (sig == SIG_TIMEOUT + TMR_SUPER_SPIN) return MODE_SEARCH_WALL;
         end
         MODE_PUSH: begin
            if (sig == SIG_ENTER) push_cmd(DIR_FWD, DUTY_BASE, DIR_FWD, DUTY_BASE);
            else if ((sig == EV_BOOM_FRONT || sig == EV_BOOM_BACK) && act)
               push_cmd(DIR_FWD, DUTY_TWO_THRD, DIR_FWD, DUTY_TWO_THRD);
            else if (sig == EV_FRONT_LEFT && act) return MODE_PUSH_RIGHT;
            else if (sig == EV_FRONT_RIGHT && act) return MODE_PUSH_LEFT;
         end
         MODE_PUSH_LEFT: begin
            if (sig == SIG_ENTER) push_cmd(DIR_REV, DUTY_SPIN, DIR_FWD, DUTY_SPIN);
            else if (sig == EV_FRONT_RIGHT) begin
               if (act) push_cmd(DIR_REV, DUTY_SPIN, DIR_FWD, DUTY_SPIN);
               else push_cmd(DIR_FWD, DUTY_BASE, DIR_FWD, DUTY_BASE);
            end
            else if (sig == EV_FRONT_LEFT && act) return MODE_REVERSE;
         end
         MODE_PUSH_RIGHT: begin
            if (sig == SIG_ENTER) push_cmd(DIR_FWD, DUTY_SPIN, DIR_REV, DUTY_SPIN);
            else if (sig == EV_FRONT_LEFT) begin
               if (act) push_cmd(DIR_FWD, DUTY_SPIN, DIR_REV, DUTY_SPIN);
               else push_cmd(DIR_FWD, DUTY_BASE, DIR_FWD, DUTY_BASE);
            end
            else if (sig == EV_FRONT_RIGHT && act) return MODE_REVERSE;
         end
         MODE_REVERSE: begin
            if (sig == SIG_ENTER) begin
               arm_timer(TMR_REVERSE);
               push_cmd(DIR_REV, DUTY_BASE, DIR_REV, DUTY_REV_B);
            end
            else if (sig == SIG_TIMEOUT + TMR_REVERSE) return MODE_DRIFT_ON;
            else if ((sig == EV_BACK_LEFT || sig == EV_BACK_RIGHT) && act)
               return MODE_DRIFT_ON;
         end
         MODE_SCRAMBLE: begin
            if (sig == SIG_ENTER) begin
               arm_timer(TMR_SCRAMBLE);
               push_cmd(DIR_REV, DUTY_SPIN, DIR_FWD, DUTY_SPIN);
            end
            else if (sig == SIG_TIMEOUT + TMR_SCRAMBLE || sig == EV_TARGET)
               return MODE_SEARCH_WALL;
         end
         default: ;
      endcase
      return NO_MOVE;
   endfunction

   function automatic void enter_mode(int next_mode);
      void'(mode_react(SIG_LEAVE, 0, 0));
      cur_mode = next_mode;
      void'(mode_react(SIG_ENTER, 0, 0));
   endfunction

   function automatic void deliver(int sig, int a, int b);
      int next_mode;
      if (sig == EV_BOOM_BACK) boom_back = a != 0;
      next_mode = mode_react(sig, a, b);
      if (next_mode != NO_MOVE) enter_mode(next_mode);
   endfunction

   // work out the motor commands one accepted request causes
   function automatic void predict_commands(req_item_type r);
      int n0;
      int unsigned old;
      n0 = cmd_exp_q.size();
      if (r.op == OP_START) begin
         cur_mode = MODE_INIT;
         enter_mode(mode_sel ? MODE_SEARCH_WALL : MODE_PUSH);
      end else if (r.op == OP_TICK) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            if (!tmr_armed[t]) continue;
            old = tmr_count[t];
            tmr_count[t] = old < TIMER_MAX ? old + 1 : TIMER_MAX;
            if (old >= tmr_limit[t]) begin
               deliver(SIG_TIMEOUT + t, 0, 0);
               tmr_armed[t] = 0;
            end
         end
      end else if (r.op == OP_EVENT && r.kind <= EV_BACK_RIGHT) begin
         deliver(r.kind, r.pa, r.pb);
      end
      if (cmd_exp_q.size() > n0) cmd_exp_q[$].last = 1;
   endfunction

   // driver: hold while stalled, predict on each transfer
   always @(posedge clock) begin
      req_item_type r;
      if (reset) begin
         req_if.valid <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            r.op = req_if.op; r.kind = req_if.event_kind;
            r.pa = req_if.param_a; r.pb = req_if.param_b;
            predict_commands(r);
         end
         if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            r = pending_q.pop_front();
            req_if.op <= r.op;
            req_if.event_kind <= r.kind;
            req_if.param_a <= r.pa;
            req_if.param_b <= r.pb;
            req_if.valid <= 1;
         end else begin
            req_if.valid <= 0;
         end
      end
   end

   // result sink: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 0;
      else if (hold_left > 0) begin
         rsp_if.ready <= 0;
         hold_left <= hold_left - 1;
      end else rsp_if.ready <= $urandom_range(99) >= rx_idle_pct;
   end

   // monitor: compare each transfer with the oldest expected command
   always @(posedge clock) begin
      motor_cmd_exp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (cmd_exp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected command mode=%0d", rsp_if.mode_now);
         end else begin
            e = cmd_exp_q.pop_front();
            if (rsp_if.motor_a_dir !== e.a_dir || rsp_if.motor_a_duty !== e.a_duty ||
                rsp_if.motor_b_dir !== e.b_dir || rsp_if.motor_b_duty !== e.b_duty ||
                rsp_if.mode_now !== e.mode || rsp_if.last !== e.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("cmd exp %0d/%0d %0d/%0d m%0d l%0d got %0d/%0d %0d/%0d m%0d l%0d",
                     e.a_dir, e.a_duty, e.b_dir, e.b_duty, e.mode, e.last,
                     rsp_if.motor_a_dir, rsp_if.motor_a_duty, rsp_if.motor_b_dir,
                     rsp_if.motor_b_duty, rsp_if.mode_now, rsp_if.last);
            end
         end
      end
   end

   function automatic void add_req(int op, int kind, int pa, int pb);
      req_item_type r;
      r.op = 2'(op); r.kind = 3'(kind); r.pa = 9'(pa); r.pb = 9'(pb);
      pending_q.push_back(r);
   endfunction

   // mostly starts, ticks and meaningful events, with a little noise
   function automatic void add_random(int count);
      int pick;
      logic [8:0] pa;
      logic [8:0] pb;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         pa = $urandom_range(1) ? 9'd0 : 9'($urandom_range(256));
         pb = 9'($urandom_range(256));
         if (pick < 6) add_req(OP_START, 3'($urandom), pa, pb);
         else if (pick < 50) add_req(OP_TICK, 3'($urandom), pa, pb);
         else if (pick < 60) add_req(OP_EVENT, EV_TARGET,
                                     9'($urandom_range(CTR_X_LO, CTR_X_HI)),
                                     9'($urandom_range(CTR_Y_LO, 256)));
         else if (pick < 96) add_req(OP_EVENT, 3'($urandom_range(EV_BACK_RIGHT)), pa, pb);
         else add_req(2'($urandom), 3'($urandom), 9'($urandom), 9'($urandom));
      end
   endfunction

   task automatic drain();
      while (pending_q.size() != 0 || req_if.valid || cmd_exp_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == REG_SEARCH_MODE) mode_sel = value[0];
      else tmr_limit[idx - REG_SEARCH_MODE - 1] = value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic set_limits(int lo, int hi);
      for (int t = 0; t < NUM_TIMERS; t++)
         write_reg(3'(REG_SEARCH_MODE + 1 + t), 12'($urandom_range(hi, lo)));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: push mode from defaults, target, front, boom front and back left events, and noise
      add_req(OP_TICK, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_FRONT_LEFT, 1, 0);
      add_req(OP_START, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_BOOM_FRONT, 9'h1FF, 0);
      add_req(OP_EVENT, EV_TARGET, 128, 256);
      add_req(OP_EVENT, EV_FRONT_LEFT, 256, 0);
      add_req(OP_EVENT, EV_FRONT_LEFT, 0, 0);
      add_req(OP_EVENT, EV_FRONT_RIGHT, 5, 0);
      add_req(OP_EVENT, EV_BACK_LEFT, 1, 0);
      add_req(2'd3, EV_TARGET, 1, 1);
      add_req(OP_EVENT, 3'd7, 1, 1);
      drain();
      // directed: wall search, steering extremes and centered target
      write_reg(REG_SEARCH_MODE, 12'd1);
      set_limits(0, 0);
      add_req(OP_START, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_TARGET, 127, 0);
      add_req(OP_EVENT, EV_BOOM_BACK, 0, 0);
      add_req(OP_EVENT, EV_TARGET, 129, 9'h1FF);
      add_req(OP_EVENT, EV_TARGET, 9'h1FF, 0);
      add_req(OP_EVENT, EV_BOOM_BACK, 1, 0);
      add_req(OP_EVENT, EV_BOOM_BACK, 0, 0);
      add_req(OP_EVENT, EV_BOOM_FRONT, 0, 0);
      add_req(OP_TICK, EV_TARGET, 0, 0);
      add_req(OP_TICK, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_TARGET, 0, 0);
      add_req(OP_EVENT, EV_TARGET, 90, 193);
      add_req(OP_TICK, EV_TARGET, 0, 0);
      drain();
      // random, small timer limits
      set_limits(0, 6);
      add_random(150);
      drain();
      // receiver holds off while the sender keeps offering
      tx_idle_pct = 74; rx_idle_pct = 6;
      write_reg(REG_SEARCH_MODE, 12'd0);
      set_limits(1, 4);
      hold_left <= 400;
      add_random(100);
      drain();
      // largest limits, timers never fire
      write_reg(REG_SEARCH_MODE, 12'd1);
      set_limits(4095, 4095);
      add_random(50);
      drain();
      tx_idle_pct = 0; rx_idle_pct = 0;
      set_limits(0, 8);
      add_random(150);
      drain();
      if (mismatch_count == 0 && cmd_exp_q.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

>>> files.f
rtl/rtss_pkg.sv
rtl/rtss_req_if.sv
rtl/rtss_rsp_if.sv
rtl/rtss_ctrl.sv
rtl/rtss_datapath.sv
rtl/robot_target_search_sequencer.sv
rtl/rtss_checker.sv
tb/sv/testbench.sv
